/* rtl/core/dotp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the dhcp option tlv parser
package dotp_pkg;

    localparam int FIELD_BYTES_DEF = 312;
    localparam int COOKIE_BYTES    = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CODE_PAD = 8'd0;
    localparam logic [7:0] CODE_END = 8'd255;

    localparam logic [1:0] KIND_OPTION    = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_BOGUS     = 2'd2;
    localparam logic [1:0] KIND_EXHAUSTED = 2'd3;

    typedef enum logic [1:0] {
        PH_COOKIE = 2'd0,
        PH_CODE   = 2'd1,
        PH_LEN    = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic [7:0] length;
        logic [8:0] offset;
        logic       last;
    } rec_t;

    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

/* rtl/core/dotp_if.sv */
`timescale 1ns / 1ps
// handshake interfaces for option bytes and parse records
interface dotp_in_if;
    logic       valid;
    logic       ready;
    logic       first_byte;
    logic [7:0] data_byte;

    modport source (output valid, output first_byte, output data_byte, input ready);
    modport sink (input valid, input first_byte, input data_byte, output ready);
endinterface

interface dotp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] record_kind;
    logic [7:0] option_code;
    logic [7:0] option_length;
    logic [8:0] value_offset;
    logic       last_record;

    modport source (output valid, output record_kind, output option_code,
                    output option_length, output value_offset, output last_record,
                    input ready);
    modport sink (input valid, input record_kind, input option_code,
                  input option_length, input value_offset, input last_record,
                  output ready);
endinterface

/* rtl/core/dhcp_option_tlv_parser_top.sv */
`timescale 1ns / 1ps
// top level of the dhcp option tlv parser
//
//   channel    dir  payload                                             handshake
//   opt_bytes  in   first_byte, data_byte                               valid/ready
//   records    out  record_kind, option_code, option_length,            valid/ready
//                   value_offset, last_record
//
// one byte per cycle unless stalled; records pass the input register, then the queue
// the byte ending the field can give two records, both pushed into a four-record queue
// input stalls while a byte is held and the queue has fewer than two free slots
// reset puts the parser at offset 0 in the cookie phase with an empty queue
module dhcp_option_tlv_parser_top #(
    parameter int FIELD_BYTES = dotp_pkg::FIELD_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dotp_in_if.sink    opt_bytes,
    dotp_out_if.source records
);
    import dotp_pkg::*;

    push_t push;
    logic  space_ok;

    dotp_parse #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .opt_bytes (opt_bytes),
        .space_ok  (space_ok),
        .push      (push)
    );

    dotp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .records  (records)
    );

endmodule

/* rtl/core/dotp_parse.sv */
`timescale 1ns / 1ps
// input register and per-byte tlv parse step
module dotp_parse #(
    parameter int FIELD_BYTES = dotp_pkg::FIELD_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    dotp_in_if.sink         opt_bytes,
    input  logic            space_ok,
    output dotp_pkg::push_t push
);
    import dotp_pkg::*;

    localparam int POS_W = $clog2(FIELD_BYTES + 1);
    localparam int EXT_W = POS_W + 9;
    localparam logic [POS_W-1:0] FIELD_END   = POS_W'(FIELD_BYTES);
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FIELD_BYTES - 1);
    localparam logic [POS_W-1:0] COOKIE_LAST = POS_W'(COOKIE_BYTES - 1);
    localparam logic [EXT_W-1:0] LAST_EXT    = EXT_W'(FIELD_BYTES - 1);

    logic             in_valid_reg;
    logic             in_first_reg;
    logic [7:0]       in_byte_reg;
    logic             adv;

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       left_reg, left_next;

    phase_t           eff_phase;
    logic [POS_W-1:0] eff_pos;
    logic [7:0]       eff_code;
    logic [7:0]       eff_left;
    logic             active;
    logic             is_last;
    logic             bogus;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] len_sum;
    logic [EXT_W-1:0] off_sum;

    logic             main_v;
    logic [1:0]       main_kind;
    logic             exh_v;
    rec_t             main_rec;
    rec_t             exh_rec;

    assign adv             = in_valid_reg && space_ok;
    assign opt_bytes.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (opt_bytes.ready)
        begin
            in_valid_reg <= opt_bytes.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_first_reg <= 1'b0;
            in_byte_reg  <= 8'd0;
        end
        else if (opt_bytes.valid && opt_bytes.ready)
        begin
            in_first_reg <= opt_bytes.first_byte;
            in_byte_reg  <= opt_bytes.data_byte;
        end
    end

    // a marked first byte restarts parsing before it is taken
    assign eff_phase = in_first_reg ? PH_COOKIE : phase_reg;
    assign eff_pos   = in_first_reg ? '0 : pos_reg;
    assign eff_code  = in_first_reg ? 8'd0 : code_reg;
    assign eff_left  = in_first_reg ? 8'd0 : left_reg;

    assign active  = (eff_pos < FIELD_END) && (eff_phase != PH_STOP);
    assign is_last = (eff_pos == LAST_POS);
    assign pos_ext = {9'd0, eff_pos};
    assign len_sum = pos_ext + EXT_W'(in_byte_reg);
    assign off_sum = pos_ext + EXT_W'(1);
    assign bogus   = (len_sum > LAST_EXT);

    // next state
    always_comb
    begin
        phase_next = eff_phase;
        code_next  = eff_code;
        left_next  = eff_left;
        pos_next   = (eff_pos < FIELD_END) ? eff_pos + POS_W'(1) : eff_pos;
        if (active)
        begin
            unique case (eff_phase)
                PH_COOKIE:
                begin
                    if (eff_pos >= COOKIE_LAST)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    priority if (eff_left != 8'd0)
                    begin
                        left_next = eff_left - 8'd1;
                    end
                    else if (in_byte_reg == CODE_PAD)
                    begin
                        phase_next = PH_CODE;
                    end
                    else if (in_byte_reg == CODE_END)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        code_next  = in_byte_reg;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (bogus)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        left_next  = in_byte_reg;
                        phase_next = PH_CODE;
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
            endcase
            if (is_last)
            begin
                phase_next = PH_STOP;
            end
        end
    end

    // records of this byte
    always_comb
    begin
        main_v    = 1'b0;
        main_kind = KIND_OPTION;
        if (active)
        begin
            unique case (eff_phase)
                PH_CODE:
                begin
                    if (eff_left == 8'd0 && in_byte_reg == CODE_END)
                    begin
                        main_v    = 1'b1;
                        main_kind = KIND_END;
                    end
                end
                PH_LEN:
                begin
                    main_v    = 1'b1;
                    main_kind = bogus ? KIND_BOGUS : KIND_OPTION;
                end
                PH_COOKIE, PH_STOP:
                begin
                    main_v = 1'b0;
                end
            endcase
        end
        exh_v = active && is_last && !(main_v && main_kind != KIND_OPTION);

        main_rec.kind   = main_kind;
        main_rec.code   = (main_kind == KIND_OPTION) ? eff_code : 8'd0;
        main_rec.length = (main_kind == KIND_OPTION) ? in_byte_reg : 8'd0;
        main_rec.offset = (main_kind == KIND_OPTION) ? off_sum[8:0] : 9'd0;
        main_rec.last   = !exh_v;

        exh_rec.kind    = KIND_EXHAUSTED;
        exh_rec.code    = 8'd0;
        exh_rec.length  = 8'd0;
        exh_rec.offset  = 9'd0;
        exh_rec.last    = 1'b1;

        push.cnt  = adv ? ({1'b0, main_v} + {1'b0, exh_v}) : 2'd0;
        push.rec0 = main_v ? main_rec : exh_rec;
        push.rec1 = exh_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_COOKIE;
            code_reg  <= 8'd0;
            left_reg  <= 8'd0;
        end
        else if (adv)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
        end
    end

`ifndef SYNTHESIS
    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !in_first_reg && phase_reg == PH_STOP) |-> (push.cnt == 2'd0))
        else $error("stopped parser produced a record");

    a_two_ends_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.rec0.kind == KIND_OPTION && push.rec0.last == 1'b0
                                && push.rec1.kind == KIND_EXHAUSTED))
        else $error("second record of a byte is not field exhausted");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (pos_reg <= FIELD_END))
        else $error("byte position ran past the field");
`endif

endmodule

/* rtl/core/dotp_queue.sv */
`timescale 1ns / 1ps
// small record queue taking up to two records per cycle
module dotp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  dotp_pkg::push_t push,
    output logic            space_ok,
    dotp_out_if.source      records
);
    import dotp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);
    localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(QUEUE_DEPTH);

    rec_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    rec_t             head;

    assign space_ok = (cnt_reg <= ROOM_LIMIT);
    assign pop      = records.valid && records.ready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(push.cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.rec0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head                  = mem[rd_ptr_reg];
    assign records.valid         = (cnt_reg != '0);
    assign records.record_kind   = head.kind;
    assign records.option_code   = head.code;
    assign records.option_length = head.length;
    assign records.value_offset  = head.offset;
    assign records.last_record   = head.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (space_ok && cnt_reg <= FULL_CNT - CNT_W'(push.cnt)))
        else $error("record queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg <= FULL_CNT))
        else $error("record queue count out of range");
`endif

endmodule
